// File: rtl/core/gbb_pkg.sv
// ----------------------------------------------------------------------------
// gbb_pkg
// Shared types and constants of the glyph bitmap blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package gbb_pkg;

  // default screen geometry
  localparam int unsigned ScreenWidthDef  = 800;
  localparam int unsigned ScreenHeightDef = 480;

  // glyph pixels carried by one input byte, one lane each
  localparam int unsigned NumLanes = 8;
  localparam int unsigned LaneW    = 3;

  // field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned AddrW  = 19;
  localparam int unsigned ColorW = 32;
  localparam int unsigned OrgW   = 12;
  localparam int unsigned RbW    = 6;
  localparam int unsigned HgtW   = 7;
  localparam int unsigned ColW   = 5;
  localparam int unsigned RowW   = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  // signed screen coordinates of the lanes, wide enough for a 4096 screen
  localparam int unsigned XW = 14;
  localparam int unsigned YW = 14;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgOriginX     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgOriginY     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRowBytes    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgGlyphHeight = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPixelColor  = 3'd4;

  // one byte after the lanes: which pixels land on screen, and where
  typedef struct packed {
    logic [NumLanes-1:0]  hit;    // bit 0 is the leftmost pixel
    logic signed [XW-1:0] xbase;  // screen column of the leftmost pixel
    logic signed [YW-1:0] y;      // screen row
  } lane_item_t;

endpackage

`default_nettype wire

// File: rtl/core/glyph_bitmap_blitter.sv
// ----------------------------------------------------------------------------
// glyph_bitmap_blitter
// Expands one-bit glyph bytes into framebuffer pixel writes.
// ----------------------------------------------------------------------------
// The first pixel write of a byte passes the lane result register, the merge
// buffer and the output register. One pixel write per cycle leaves the merge
// buffer unless the receiver stalls; eight lanes clip all pixels at once.
// Reset clears the glyph position and the pipeline valid state and loads the
// register defaults; no clearing pass is needed.
`default_nettype none

module glyph_bitmap_blitter #(
  parameter int unsigned SCREEN_WIDTH  = gbb_pkg::ScreenWidthDef,
  parameter int unsigned SCREEN_HEIGHT = gbb_pkg::ScreenHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gbb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [gbb_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [gbb_pkg::ByteW-1:0]     glyph_byte_i,
  input  logic                          first_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [gbb_pkg::AddrW-1:0]     pixel_address_o,
  output logic [gbb_pkg::ColorW-1:0]    color_out_o,
  output logic                          last_pixel_o
);
  import gbb_pkg::*;

  localparam logic signed [YW-1:0] HeightS = YW'(SCREEN_HEIGHT);

  logic [OrgW-1:0]   origin_x_q;
  logic [OrgW-1:0]   origin_y_q;
  logic [RbW-1:0]    row_bytes_q;
  logic [HgtW-1:0]   glyph_height_q;
  logic [ColorW-1:0] pixel_color_q;

  logic [ColW-1:0]   col_q, col_d, col_cur;
  logic [RowW-1:0]   row_q, row_d, row_cur;
  logic [RbW-1:0]    rb_eff;

  logic              accept;
  logic              a_valid_q;
  lane_item_t        a_item_q, a_item_d;
  logic              a_ready;
  logic              row_ok;

  logic [NumLanes-1:0]  lane_hit;
  logic signed [YW-1:0] y_cur;
  logic signed [XW-1:0] xbase_cur;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q     <= '0;
      origin_y_q     <= '0;
      row_bytes_q    <= RbW'(3);
      glyph_height_q <= HgtW'(46);
      pixel_color_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgOriginX:     origin_x_q     <= cfg_data_i[OrgW-1:0];
        CfgOriginY:     origin_y_q     <= cfg_data_i[OrgW-1:0];
        CfgRowBytes:    row_bytes_q    <= cfg_data_i[RbW-1:0];
        CfgGlyphHeight: glyph_height_q <= cfg_data_i[HgtW-1:0];
        CfgPixelColor:  pixel_color_q  <= cfg_data_i[ColorW-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = a_valid_q && !a_ready;
  assign accept     = in_valid_i && !in_stall_o;

  // glyph position, restarted by the first byte
  always_comb begin
    col_cur = first_byte_i ? '0 : col_q;
    row_cur = first_byte_i ? '0 : row_q;
    if (row_bytes_q == '0) begin
      rb_eff = RbW'(1);
    end else if (row_bytes_q > RbW'(32)) begin
      rb_eff = RbW'(32);
    end else begin
      rb_eff = row_bytes_q;
    end
    if ((RbW'(col_cur) + RbW'(1)) >= rb_eff) begin
      col_d = '0;
      row_d = (row_cur < RowW'(127)) ? row_cur + RowW'(1) : row_cur;
    end else begin
      col_d = col_cur + ColW'(1);
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // screen row and column of the leftmost pixel
  always_comb begin
    y_cur     = YW'($signed(origin_y_q)) + $signed({(YW-RowW)'(0), row_cur});
    xbase_cur = XW'($signed(origin_x_q)) + $signed({(XW-ColW-3)'(0), col_cur, 3'b000});
  end

  assign row_ok = (row_cur < glyph_height_q) && (y_cur >= 0) && (y_cur < HeightS);

  // pixel lanes, lane 0 takes bit 7
  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    gbb_lane #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .LANE         (g)
    ) u_lane (
      .pix_i    (glyph_byte_i[NumLanes-1-g]),
      .row_ok_i (row_ok),
      .xbase_i  (xbase_cur),
      .hit_o    (lane_hit[g])
    );
  end

  assign a_item_d = {lane_hit, xbase_cur, y_cur};

  // lane result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (accept) begin
      a_valid_q <= 1'b1;
    end else if (a_ready) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_item_q <= a_item_d;
    end
  end

  // merge and output transfer
  gbb_merge #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .a_valid_i       (a_valid_q),
    .a_item_i        (a_item_q),
    .a_ready_o       (a_ready),
    .color_i         (pixel_color_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pixel_address_o (pixel_address_o),
    .color_out_o     (color_out_o),
    .last_pixel_o    (last_pixel_o)
  );

endmodule

`default_nettype wire

// File: rtl/core/gbb_lane.sv
// ----------------------------------------------------------------------------
// gbb_lane
// One pixel lane: decides whether its glyph pixel is set and on screen.
// ----------------------------------------------------------------------------
`default_nettype none

module gbb_lane #(
  parameter int unsigned SCREEN_WIDTH = gbb_pkg::ScreenWidthDef,
  parameter int unsigned LANE         = 0
) (
  input  logic                        pix_i,
  input  logic                        row_ok_i,
  input  logic signed [gbb_pkg::XW-1:0] xbase_i,
  output logic                        hit_o
);
  import gbb_pkg::*;

  localparam logic signed [XW-1:0] WidthS = XW'(SCREEN_WIDTH);

  logic signed [XW-1:0] x;

  // column of this lane and horizontal clip
  assign x     = xbase_i + XW'(LANE);
  assign hit_o = pix_i && row_ok_i && (x >= 0) && (x < WidthS);

endmodule

`default_nettype wire

// File: rtl/core/gbb_merge.sv
// ----------------------------------------------------------------------------
// gbb_merge
// Merges the lane hits of one byte into pixel writes, leftmost first.
// ----------------------------------------------------------------------------
`default_nettype none

module gbb_merge #(
  parameter int unsigned SCREEN_WIDTH  = gbb_pkg::ScreenWidthDef,
  parameter int unsigned SCREEN_HEIGHT = gbb_pkg::ScreenHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          a_valid_i,
  input  gbb_pkg::lane_item_t           a_item_i,
  output logic                          a_ready_o,
  input  logic [gbb_pkg::ColorW-1:0]    color_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [gbb_pkg::AddrW-1:0]     pixel_address_o,
  output logic [gbb_pkg::ColorW-1:0]    color_out_o,
  output logic                          last_pixel_o
);
  import gbb_pkg::*;

  localparam int unsigned YuW = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
  localparam int unsigned RaW = YuW + $clog2(SCREEN_WIDTH) + 1;
  localparam int unsigned SumW = RaW + 1;

  logic [NumLanes-1:0]  mask_q;
  logic signed [XW-1:0] xbase_q;
  logic [RaW-1:0]       row_addr_q;
  logic [RaW-1:0]       row_addr_d;

  logic                 out_valid_q;
  logic [AddrW-1:0]     addr_q;
  logic [ColorW-1:0]    color_q;
  logic                 last_q;

  logic                 out_free;
  logic                 pick;
  logic [LaneW-1:0]     pick_lane;
  logic [NumLanes-1:0]  rest;
  logic                 load;
  logic signed [XW-1:0] x_pick;
  logic [XW-2:0]        x_u;
  logic [SumW-1:0]      addr_sum;
  logic [YuW-1:0]       y_u;

  // leftmost pending lane
  always_comb begin
    pick_lane = '0;
    for (int i = NumLanes - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        pick_lane = LaneW'(i);
      end
    end
  end

  // handshake between lanes, merge buffer and output register
  assign out_free  = !out_valid_q || !out_stall_i;
  assign pick      = (|mask_q) && out_free;
  assign rest      = mask_q & ~(NumLanes'(1) << pick_lane);
  assign load      = a_valid_i && (!(|mask_q) || (pick && !(|rest)));
  assign a_ready_o = load;

  // row start address, registered before the column add
  assign y_u        = a_item_i.y[YuW-1:0];
  assign row_addr_d = RaW'(y_u) * RaW'(SCREEN_WIDTH);

  // pixel address of the picked lane
  assign x_pick   = xbase_q + XW'(pick_lane);
  assign x_u      = x_pick[XW-2:0];
  assign addr_sum = SumW'(row_addr_q) + SumW'(x_u);

  // merge buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (load) begin
      mask_q <= a_item_i.hit;
    end else if (pick) begin
      mask_q <= rest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      xbase_q    <= a_item_i.xbase;
      row_addr_q <= row_addr_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= pick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pick) begin
      addr_q  <= AddrW'(addr_sum);
      color_q <= color_i;
      last_q  <= !(|rest);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_address_o = addr_q;
  assign color_out_o     = color_q;
  assign last_pixel_o    = last_q;

endmodule

`default_nettype wire

// File: verif/gbb_blit_check.sv
// ----------------------------------------------------------------------------
// gbb_blit_check
// Watches the glyph blitter's ports and checks every pixel write.
// Mirrors the register writes, predicts the pixel writes of each accepted
// glyph byte from its own copy of the glyph position, and compares each
// output transfer field by field with the oldest predicted write.
// ----------------------------------------------------------------------------
`default_nettype none

module gbb_blit_check #(
  parameter int unsigned SCREEN_WIDTH  = gbb_pkg::ScreenWidthDef,
  parameter int unsigned SCREEN_HEIGHT = gbb_pkg::ScreenHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gbb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [gbb_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [gbb_pkg::ByteW-1:0]     glyph_byte_i,
  input  logic                          first_byte_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [gbb_pkg::AddrW-1:0]     pixel_address_i,
  input  logic [gbb_pkg::ColorW-1:0]    color_out_i,
  input  logic                          last_pixel_i,
  output int                            fail_count_o,
  output int                            writes_pending_o,
  output int                            bytes_seen_o,
  output int                            bytes_drawn_o,
  output int                            pixels_seen_o
);

  typedef struct packed {
    logic [gbb_pkg::AddrW-1:0]  addr;
    logic [gbb_pkg::ColorW-1:0] color;
    logic                       last;
  } pixel_write_t;

  // register copy
  logic signed [gbb_pkg::OrgW-1:0] org_x;
  logic signed [gbb_pkg::OrgW-1:0] org_y;
  logic [gbb_pkg::RbW-1:0]         row_bytes;
  logic [gbb_pkg::HgtW-1:0]        glyph_height;
  logic [gbb_pkg::ColorW-1:0]      pixel_color;

  // glyph position of the next byte
  logic [gbb_pkg::ColW-1:0] byte_col;
  logic [gbb_pkg::RowW-1:0] glyph_row;

  pixel_write_t writes_due[$];
  int fails;
  int shown;
  int n_bytes;
  int n_drawn;
  int n_pixels;

  task automatic note_mismatch(input string field, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    fails++;
    if (shown < 30) begin
      shown++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, exp_v, act_v);
    end
  endtask

  // predict the pixel writes of one glyph byte and advance the position
  task automatic blit_byte(input logic [gbb_pkg::ByteW-1:0] bits, input logic restart);
    int rb;
    int ox;
    int oy;
    int x;
    int y;
    int b;
    int lin;
    logic [7:0] on_screen;
    logic [7:0] below;
    pixel_write_t w;
    if (restart) begin
      byte_col  = '0;
      glyph_row = '0;
    end
    rb = int'(row_bytes);
    if (rb == 0) rb = 1;
    else if (rb > 32) rb = 32;
    on_screen = '0;
    ox = org_x;
    oy = org_y;
    y  = oy + int'(glyph_row);
    if (glyph_row < glyph_height) begin
      n_drawn++;
      // clip every set pixel against the screen
      for (b = 7; b >= 0; b--) begin
        x = ox + int'(byte_col) * 8 + (7 - b);
        if (bits[b] && x >= 0 && x < int'(SCREEN_WIDTH) && y >= 0 &&
            y < int'(SCREEN_HEIGHT)) begin
          on_screen[b] = 1'b1;
        end
      end
      // leftmost first; the last flag goes on the rightmost visible pixel
      for (b = 7; b >= 0; b--) begin
        if (on_screen[b]) begin
          x       = ox + int'(byte_col) * 8 + (7 - b);
          below   = (8'd1 << b) - 8'd1;
          lin     = x + y * int'(SCREEN_WIDTH);
          w.addr  = lin[gbb_pkg::AddrW-1:0];
          w.color = pixel_color;
          w.last  = ((on_screen & below) == 8'd0);
          writes_due.push_back(w);
        end
      end
    end
    // column and row advance, row saturates
    if (int'(byte_col) + 1 >= rb) begin
      byte_col = '0;
      if (glyph_row < 7'd127) glyph_row = glyph_row + 7'd1;
    end else begin
      byte_col = byte_col + 5'd1;
    end
  endtask

  // output transfers, register writes and input transfers of each edge
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_write_t w;
    if (!rst_ni) begin
      org_x        = '0;
      org_y        = '0;
      row_bytes    = 6'd3;
      glyph_height = 7'd46;
      pixel_color  = '0;
      byte_col     = '0;
      glyph_row    = '0;
      writes_due.delete();
      fails    = 0;
      shown    = 0;
      n_bytes  = 0;
      n_drawn  = 0;
      n_pixels = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        n_pixels++;
        if (writes_due.size() == 0) begin
          note_mismatch("unexpected pixel write, address", 32'd0, 32'(pixel_address_i));
        end else begin
          w = writes_due.pop_front();
          if (pixel_address_i !== w.addr)
            note_mismatch("pixel_address", 32'(w.addr), 32'(pixel_address_i));
          if (color_out_i !== w.color)
            note_mismatch("color_out", w.color, color_out_i);
          if (last_pixel_i !== w.last)
            note_mismatch("last_pixel", 32'(w.last), 32'(last_pixel_i));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gbb_pkg::CfgOriginX:     org_x        = cfg_data_i[gbb_pkg::OrgW-1:0];
          gbb_pkg::CfgOriginY:     org_y        = cfg_data_i[gbb_pkg::OrgW-1:0];
          gbb_pkg::CfgRowBytes:    row_bytes    = cfg_data_i[gbb_pkg::RbW-1:0];
          gbb_pkg::CfgGlyphHeight: glyph_height = cfg_data_i[gbb_pkg::HgtW-1:0];
          gbb_pkg::CfgPixelColor:  pixel_color  = cfg_data_i[gbb_pkg::ColorW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        n_bytes++;
        blit_byte(glyph_byte_i, first_byte_i);
      end
    end
    fail_count_o     <= fails;
    writes_pending_o <= writes_due.size();
    bytes_seen_o     <= n_bytes;
    bytes_drawn_o    <= n_drawn;
    pixels_seen_o    <= n_pixels;
  end

endmodule

`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the glyph bitmap blitter.
// A directed pass walks reset defaults, clipping on every screen edge, the
// row_bytes and glyph_height corner values and a mid-glyph width change;
// random phases then send glyphs under fresh register setups with random
// sender gaps and receiver stalls, while gbb_blit_check does the checking.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int IdleLimit  = 4000;
  localparam int SentTarget = 390;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [gbb_pkg::CfgIdxW-1:0]   cfg_idx;
  logic [gbb_pkg::CfgDataW-1:0]  cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic [gbb_pkg::ByteW-1:0]     glyph_byte;
  logic                          first_byte;
  logic                          out_valid;
  logic                          out_stall;
  logic [gbb_pkg::AddrW-1:0]     pixel_address;
  logic [gbb_pkg::ColorW-1:0]    color_out;
  logic                          last_pixel;

  int  fails;
  int  writes_pending;
  int  bytes_seen;
  int  bytes_drawn;
  int  pixels_seen;
  int  setups;
  int  idle_cycles;
  bit  quiet;

  glyph_bitmap_blitter DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .glyph_byte_i    (glyph_byte),
    .first_byte_i    (first_byte),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .pixel_address_o (pixel_address),
    .color_out_o     (color_out),
    .last_pixel_o    (last_pixel)
  );

  gbb_blit_check blit_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .glyph_byte_i     (glyph_byte),
    .first_byte_i     (first_byte),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .pixel_address_i  (pixel_address),
    .color_out_i      (color_out),
    .last_pixel_i     (last_pixel),
    .fail_count_o     (fails),
    .writes_pending_o (writes_pending),
    .bytes_seen_o     (bytes_seen),
    .bytes_drawn_o    (bytes_drawn),
    .pixels_seen_o    (pixels_seen)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // idle cycles before an item, none during quiet stretches
  function automatic int draw_gap();
    if (quiet || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80 >> $urandom_range(0, 7);
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one byte transfer; valid stays high when the next gap is zero
  task automatic send_byte(input logic [7:0] bits, input logic restart);
    int gap;
    in_valid   <= 1'b1;
    glyph_byte <= bits;
    first_byte <= restart;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // a glyph of len bytes; noisy ones get stray restart flags
  task automatic send_glyph(input int len, input bit noisy);
    int k;
    logic restart;
    for (k = 0; k < len; k++) begin
      restart = (k == 0);
      if (noisy && $urandom_range(0, 11) == 0) restart = ~restart;
      send_byte(pick_byte(), restart);
    end
  endtask

  // wait for the block to drain, then cover its pipeline latency
  task automatic settle();
    in_valid <= 1'b0;
    while (writes_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [gbb_pkg::CfgIdxW-1:0] idx,
                           input logic [gbb_pkg::CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
  endtask

  task automatic load_setup(input int ox, input int oy, input int rb, input int h,
                            input logic [31:0] color);
    write_reg(gbb_pkg::CfgOriginX, ox);
    write_reg(gbb_pkg::CfgOriginY, oy);
    write_reg(gbb_pkg::CfgRowBytes, rb);
    write_reg(gbb_pkg::CfgGlyphHeight, h);
    write_reg(gbb_pkg::CfgPixelColor, color);
    end_writes();
    setups++;
  endtask

  // receiver: random stall ahead of each pixel write
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      n = draw_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // watchdog on cycles without any transfer or register write
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int phase;
    int ox;
    int oy;
    int rb;
    int rbe;
    int h;
    int rows;
    int n;
    int sent;
    bit noisy;
    cfg_we     = 1'b0;
    cfg_idx    = gbb_pkg::CfgOriginX;
    cfg_data   = '0;
    in_valid   = 1'b0;
    glyph_byte = '0;
    first_byte = 1'b0;
    quiet      = 1'b0;
    setups     = 0;
    rst_n      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset defaults: three bytes of row 0, color zero
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    settle();

    // left edge clipping, two bytes per row, bytes past the glyph height
    load_setup(-4, 0, 2, 3, 32'hFFFF_FFFF);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'hFF, 1'b0);
    settle();

    // right and top edges, zero row_bytes acts as one
    load_setup(796, -1, 0, 2, 32'h1234_5678);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    settle();

    // most negative x and largest y: everything off screen
    load_setup(-2048, 2047, 63, 64, 32'hA5A5_5A5A);
    send_byte(8'hFF, 1'b1);
    settle();

    // bottom row, oversized row_bytes held at 32
    load_setup(0, 479, 63, 64, 32'h0000_0001);
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b0);
    settle();

    // row_bytes shrinks mid-glyph: held column draws, then a new row
    load_setup(100, 100, 4, 10, 32'h00C0_FFEE);
    send_byte(8'h81, 1'b1);
    send_byte(8'h42, 1'b0);
    send_byte(8'h24, 1'b0);
    settle();
    write_reg(gbb_pkg::CfgRowBytes, 32'd1);
    end_writes();
    send_byte(8'h18, 1'b0);
    send_byte(8'hF0, 1'b0);
    settle();

    // zero glyph height draws nothing
    write_reg(gbb_pkg::CfgGlyphHeight, 32'd0);
    end_writes();
    send_byte(8'hFF, 1'b1);
    settle();

    // random phases, each under a fresh setup
    phase = 0;
    while (bytes_seen < SentTarget && phase < 80) begin
      quiet = ($urandom_range(0, 4) == 0);
      if (phase == 2) begin
        // tall narrow glyph running past row 127
        load_setup($urandom_range(0, 700), 0, 1, 127, $urandom);
        send_glyph(132, 1'b0);
      end else begin
        case ($urandom_range(0, 9))
          0:       ox = -2048;
          1:       ox = 2047;
          2:       ox = -$urandom_range(1, 16);
          3:       ox = 800 - $urandom_range(1, 16);
          default: ox = $urandom_range(0, 780);
        endcase
        case ($urandom_range(0, 9))
          0:       oy = -2048;
          1:       oy = 2047;
          2:       oy = -$urandom_range(1, 8);
          3:       oy = 480 - $urandom_range(1, 8);
          default: oy = $urandom_range(0, 460);
        endcase
        case ($urandom_range(0, 9))
          0:       rb = 0;
          1:       rb = 32;
          2:       rb = $urandom_range(33, 63);
          default: rb = $urandom_range(1, 4);
        endcase
        case ($urandom_range(0, 11))
          0:       h = 0;
          1:       h = 64;
          2:       h = 127;
          default: h = $urandom_range(1, 8);
        endcase
        rbe  = (rb == 0) ? 1 : ((rb > 32) ? 32 : rb);
        rows = (h == 0) ? 2 : h;
        load_setup(ox, oy, rb, h, $urandom);
        sent = 0;
        while (sent < 30) begin
          noisy = ($urandom_range(0, 3) == 0);
          n = rows * rbe;
          if (noisy) n = n + $urandom_range(0, 3) - 1;
          if (n < 1) n = 1;
          if (n > 40) n = 40;
          send_glyph(n, noisy);
          sent = sent + n;
        end
      end
      settle();
      phase++;
    end

    quiet = 1'b0;
    settle();
    repeat (20) @(posedge clk);
    $display("run covered %0d glyph bytes (%0d inside the glyph) and %0d pixel writes",
             bytes_seen, bytes_drawn, pixels_seen);
    $display("across %0d register setups with clipping on all screen edges", setups);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
